// ===== rtl/core/ricache_pkg.sv =====
// ----------------------------------------------------------------------------
// ricache_pkg
// Shared types and constants for the reference-counted inode cache table:
// request and result beats, operation and status codes, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ricache_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int REF_BITS_DEF = 8;
    localparam int SLOT_W       = 6;
    localparam int DEVICE_W     = 8;
    localparam int OBJECT_W     = 16;
    localparam int LINKS_W      = 16;
    localparam int KEY_W        = DEVICE_W + OBJECT_W;

    typedef enum logic [1:0] {
        KIND_GET    = 2'd0,
        KIND_DUP    = 2'd1,
        KIND_PUT    = 2'd2,
        KIND_LOADED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_UNREF    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        kind_t                kind;
        logic [DEVICE_W-1:0]  device;
        logic [OBJECT_W-1:0]  object_number;
        logic [SLOT_W-1:0]    slot;
        logic [LINKS_W-1:0]   link_count;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] entry_index;
        logic              hit;
        logic              needs_load;
        logic              release_object;
        status_t           status;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_GET_DONE,
        S_SLOT
    } fsm_state_t;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic scan;
        logic get_exec;
        logic slot_exec;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_done;
        logic req_get;
    } dp_sts_t;

endpackage

// ===== rtl/core/refcounted_inode_cache_table_unit.sv =====
// ----------------------------------------------------------------------------
// refcounted_inode_cache_table_unit
// Reference-counted table of cached file-object entries: get by key, dup,
// put and mark-loaded, with saturating counts and release signalling.
//
//  channel   | direction | handshake                     | beat
//  ----------+-----------+-------------------------------+---------
//  request   | in        | start high while busy is low  | req_t
//  result    | out       | result_valid, one cycle       | rsp_t
//
//  dup, put and loaded: accept, then the execute step, after which the next
//  accept can follow; result strobed in the cycle after the execute step.
//  get: one entry per cycle through the state and key memories; the scan
//  stops at the first match or after the last entry, then the execute step.
//  reset: a clearing pass over all entries zeroes counts and loaded flags,
//  busy stays high throughout.
//  the receiver cannot stall: each result is on the port for one cycle only.
// ----------------------------------------------------------------------------
module refcounted_inode_cache_table_unit
    import ricache_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int REF_BITS = REF_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic result_valid,
    output rsp_t result
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    ricache_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    ricache_dp #(
        .ENTRIES  (ENTRIES),
        .REF_BITS (REF_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== rtl/core/ricache_ram.sv =====
// ----------------------------------------------------------------------------
// ricache_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module ricache_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ricache_ctrl.sv =====
// ----------------------------------------------------------------------------
// ricache_ctrl
// Sequencer for the cache table: clearing pass after reset, request accept,
// key scan for get, and the single execute step of each request.
// ----------------------------------------------------------------------------
module ricache_ctrl
    import ricache_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  dp_sts_t sts,
    output logic    busy,
    output dp_cmd_t cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = sts.req_get ? S_SCAN : S_SLOT;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_GET_DONE;
                end
            end
            S_GET_DONE:
            begin
                state_next = S_IDLE;
            end
            S_SLOT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy          = (state_reg != S_IDLE);
        cmd.clear_wr  = (state_reg == S_CLEAR);
        cmd.accept    = (state_reg == S_IDLE) && start;
        cmd.scan      = (state_reg == S_SCAN);
        cmd.get_exec  = (state_reg == S_GET_DONE);
        cmd.slot_exec = (state_reg == S_SLOT);
    end

endmodule

// ===== rtl/core/ricache_dp.sv =====
// ----------------------------------------------------------------------------
// ricache_dp
// Datapath of the cache table: key, link and count memories, scan pointer,
// hit and first-free capture, entry update and the result register.
// ----------------------------------------------------------------------------
module ricache_dp
    import ricache_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int REF_BITS = REF_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  req_t    request,
    input  dp_cmd_t cmd,
    output dp_sts_t sts,
    output logic    result_valid,
    output rsp_t    result
);

    localparam int                AW      = $clog2(ENTRIES);
    localparam logic [AW-1:0]     LAST    = AW'(ENTRIES - 1);
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
    localparam int                SW      = REF_BITS + 1;

    // request and scan control
    req_t                req_reg;
    logic [AW-1:0]       cnt_reg;
    logic [AW-1:0]       cnt_next;
    logic                rd_vld_reg;
    logic [AW-1:0]       rd_idx_reg;

    // scan capture
    logic                found_reg;
    logic                found_next;
    logic [AW-1:0]       found_idx_reg;
    logic [REF_BITS-1:0] found_refs_reg;
    logic                found_loaded_reg;
    logic                free_vld_reg;
    logic                free_vld_next;
    logic [AW-1:0]       free_idx_reg;

    // result
    logic                res_vld_reg;
    logic                res_vld_next;
    rsp_t                res_reg;
    rsp_t                res_next;

    // memory ports
    logic [AW-1:0]       rd_addr;
    logic                st_we;
    logic [AW-1:0]       st_waddr;
    logic [SW-1:0]       st_wdata;
    logic [SW-1:0]       st_rdata;
    logic                key_we;
    logic [KEY_W-1:0]    key_rdata;
    logic                lk_we;
    logic [LINKS_W-1:0]  lk_rdata;

    logic [REF_BITS-1:0] rd_refs;
    logic                rd_loaded;
    logic                eval;
    logic                match;
    logic [AW-1:0]       slot_addr;
    logic                slot_in_range;
    logic                unref;
    logic                sat;
    logic                found_sat;
    logic                rel;

    assign rd_refs       = st_rdata[REF_BITS:1];
    assign rd_loaded     = st_rdata[0];
    assign eval          = cmd.scan && rd_vld_reg;
    assign match         = (rd_refs != '0) &&
                           (key_rdata == {req_reg.device, req_reg.object_number});
    assign slot_addr     = AW'(req_reg.slot);
    assign slot_in_range = (32'(req_reg.slot) < ENTRIES);
    assign unref         = !slot_in_range || (rd_refs == '0);
    assign sat           = (rd_refs == REF_MAX);
    assign found_sat     = (found_refs_reg == REF_MAX);
    assign rel           = (rd_refs == REF_BITS'(1)) && rd_loaded && (lk_rdata == '0);
    assign rd_addr       = cmd.accept ? AW'(request.slot) : cnt_reg;

    assign sts.clear_last = (cnt_reg == LAST);
    assign sts.scan_done  = eval && (match || (rd_idx_reg == LAST));
    assign sts.req_get    = (request.kind == KIND_GET);

    ricache_ram #(
        .WIDTH (SW),
        .DEPTH (ENTRIES)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (rd_addr),
        .rdata (st_rdata)
    );

    ricache_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (free_idx_reg),
        .wdata ({req_reg.device, req_reg.object_number}),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    ricache_ram #(
        .WIDTH (LINKS_W),
        .DEPTH (ENTRIES)
    ) u_links_ram (
        .clk   (clk),
        .we    (lk_we),
        .waddr (slot_addr),
        .wdata (req_reg.link_count),
        .raddr (rd_addr),
        .rdata (lk_rdata)
    );

    // pointer and capture flags
    always_comb
    begin
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        free_vld_next = free_vld_reg;
        if (cmd.accept)
        begin
            cnt_next      = '0;
            found_next    = 1'b0;
            free_vld_next = 1'b0;
        end
        else
        begin
            if ((cmd.clear_wr || cmd.scan) && (cnt_reg != LAST))
            begin
                cnt_next = cnt_reg + AW'(1);
            end
            if (eval && match)
            begin
                found_next = 1'b1;
            end
            if (eval && (rd_refs == '0) && !free_vld_reg)
            begin
                free_vld_next = 1'b1;
            end
        end
    end

    // memory writes and result
    always_comb
    begin
        st_we        = 1'b0;
        st_waddr     = cnt_reg;
        st_wdata     = '0;
        key_we       = 1'b0;
        lk_we        = 1'b0;
        res_vld_next = cmd.get_exec || cmd.slot_exec;
        res_next     = res_reg;

        if (cmd.clear_wr)
        begin
            st_we = 1'b1;
        end

        if (cmd.get_exec)
        begin
            res_next.hit            = 1'b0;
            res_next.release_object = 1'b0;
            priority if (found_reg)
            begin
                st_we    = 1'b1;
                st_waddr = found_idx_reg;
                st_wdata = {found_sat ? found_refs_reg : found_refs_reg + REF_BITS'(1),
                            found_loaded_reg};
                res_next.entry_index = SLOT_W'(found_idx_reg);
                res_next.hit         = 1'b1;
                res_next.needs_load  = !found_loaded_reg;
                res_next.status      = found_sat ? ST_OVERFLOW : ST_OK;
            end
            else if (free_vld_reg)
            begin
                st_we    = 1'b1;
                st_waddr = free_idx_reg;
                st_wdata = {REF_BITS'(1), 1'b0};
                key_we   = 1'b1;
                res_next.entry_index = SLOT_W'(free_idx_reg);
                res_next.needs_load  = 1'b1;
                res_next.status      = ST_OK;
            end
            else
            begin
                res_next.entry_index = '0;
                res_next.needs_load  = 1'b0;
                res_next.status      = ST_FULL;
            end
        end

        if (cmd.slot_exec)
        begin
            res_next.entry_index    = req_reg.slot;
            res_next.hit            = 1'b0;
            res_next.needs_load     = 1'b0;
            res_next.release_object = 1'b0;
            res_next.status         = ST_OK;
            st_waddr                = slot_addr;
            if (unref)
            begin
                res_next.status = ST_UNREF;
            end
            else
            begin
                st_we = 1'b1;
                unique case (req_reg.kind)
                    KIND_GET, KIND_DUP:
                    begin
                        st_wdata            = {sat ? rd_refs : rd_refs + REF_BITS'(1),
                                               rd_loaded};
                        res_next.needs_load = !rd_loaded;
                        res_next.status     = sat ? ST_OVERFLOW : ST_OK;
                    end
                    KIND_PUT:
                    begin
                        st_wdata                = {rd_refs - REF_BITS'(1),
                                                   rd_loaded && !rel};
                        res_next.release_object = rel;
                    end
                    KIND_LOADED:
                    begin
                        st_wdata = {rd_refs, 1'b1};
                        lk_we    = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            free_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            rd_vld_reg   <= cmd.scan;
            found_reg    <= found_next;
            free_vld_reg <= free_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg;
        res_reg    <= res_next;
        if (cmd.accept)
        begin
            req_reg <= request;
        end
        if (eval && match && !found_reg)
        begin
            found_idx_reg    <= rd_idx_reg;
            found_refs_reg   <= rd_refs;
            found_loaded_reg <= rd_loaded;
        end
        if (eval && (rd_refs == '0) && !free_vld_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == ST_FULL)) |->
        ((result.entry_index == '0) && !result.hit && !result.needs_load))
        else $error("table full result carries entry fields");

    a_release_put_only: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.release_object) |->
        ((result.status == ST_OK) && !result.hit && !result.needs_load))
        else $error("release flagged on a non-put result");

    a_hit_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.hit) |-> ($past(cmd.get_exec) && $past(found_reg)))
        else $error("hit reported without a scan match");

    a_scan_stops_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> !found_reg)
        else $error("scan continued past a match");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reference-counted inode cache table. A queue of
// requests feeds a clocked driver; each accepted beat is run through a local
// model of the entry table, and a clocked monitor compares every result beat,
// field by field, with the oldest predicted one. Stimulus covers directed
// corner cases, count saturation, a full table and weighted random traffic
// over a small key pool, with the sender idling at several rates.
// ----------------------------------------------------------------------------
module tb
    import ricache_pkg::*;
();

    localparam logic [REF_BITS_DEF-1:0] REF_TOP = '1;
    localparam int POOL = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic result_valid;
    rsp_t result;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    rsp_t want;

    logic [REF_BITS_DEF-1:0] refs_held[ENTRIES_DEF];
    logic                    is_loaded[ENTRIES_DEF];
    logic [DEVICE_W-1:0]     key_dev[ENTRIES_DEF];
    logic [OBJECT_W-1:0]     key_obj[ENTRIES_DEF];
    logic [LINKS_W-1:0]      link_held[ENTRIES_DEF];

    logic [DEVICE_W-1:0] pool_dev[POOL];
    logic [OBJECT_W-1:0] pool_obj[POOL];

    int sender_idle_pct = 0;
    int items_queued = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int fault_count = 0;
    int n_hit = 0;
    int n_full = 0;
    int n_overflow = 0;
    int n_unref = 0;
    int n_release = 0;

    refcounted_inode_cache_table_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic rsp_t predict_cache(req_t rq);
        rsp_t r;
        int i;
        int free_at;
        int s;
        r = '0;
        free_at = -1;
        if (rq.kind == KIND_GET)
        begin
            for (i = 0; i < ENTRIES_DEF; i++)
            begin
                if (refs_held[i] != 0 && key_dev[i] == rq.device &&
                    key_obj[i] == rq.object_number)
                begin
                    r.entry_index = SLOT_W'(i);
                    r.hit = 1'b1;
                    r.needs_load = !is_loaded[i];
                    if (refs_held[i] == REF_TOP)
                        r.status = ST_OVERFLOW;
                    else
                        refs_held[i]++;
                    return r;
                end
                if (free_at < 0 && refs_held[i] == 0)
                    free_at = i;
            end
            if (free_at < 0)
            begin
                r.status = ST_FULL;
                return r;
            end
            key_dev[free_at] = rq.device;
            key_obj[free_at] = rq.object_number;
            refs_held[free_at] = REF_BITS_DEF'(1);
            is_loaded[free_at] = 1'b0;
            r.entry_index = SLOT_W'(free_at);
            r.needs_load = 1'b1;
            return r;
        end
        s = int'(rq.slot);
        r.entry_index = rq.slot;
        if (refs_held[s] == 0)
        begin
            r.status = ST_UNREF;
            return r;
        end
        case (rq.kind)
            KIND_DUP:
            begin
                r.needs_load = !is_loaded[s];
                if (refs_held[s] == REF_TOP)
                    r.status = ST_OVERFLOW;
                else
                    refs_held[s]++;
            end
            KIND_PUT:
            begin
                if (refs_held[s] == 1 && is_loaded[s] && link_held[s] == 0)
                begin
                    is_loaded[s] = 1'b0;
                    r.release_object = 1'b1;
                end
                refs_held[s]--;
            end
            default:
            begin
                is_loaded[s] = 1'b1;
                link_held[s] = rq.link_count;
            end
        endcase
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_rsps.push_back(predict_cache(request));
                items_accepted++;
            end
            if (!start || !busy)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    start <= 1'b1;
                    request <= pending_reqs.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_rsps.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: result beat with nothing expected: %p", $realtime, result);
            end
            else
            begin
                want = expected_rsps.pop_front();
                results_checked++;
                if (result.entry_index !== want.entry_index || result.hit !== want.hit ||
                    result.needs_load !== want.needs_load ||
                    result.release_object !== want.release_object ||
                    result.status !== want.status)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: mismatch idx/hit/load/rel/st exp %0d/%0b/%0b/%0b/%s",
                                 $realtime, want.entry_index, want.hit, want.needs_load,
                                 want.release_object, want.status.name(),
                                 " got %0d/%0b/%0b/%0b/%0d", result.entry_index,
                                 result.hit, result.needs_load, result.release_object,
                                 result.status);
                end
                n_hit += want.hit;
                n_release += want.release_object;
                n_full += (want.status == ST_FULL);
                n_overflow += (want.status == ST_OVERFLOW);
                n_unref += (want.status == ST_UNREF);
            end
        end
    end

    function automatic logic [DEVICE_W-1:0] rnd_dev();
        return DEVICE_W'($urandom);
    endfunction

    function automatic logic [OBJECT_W-1:0] rnd_obj();
        return OBJECT_W'($urandom);
    endfunction

    function automatic logic [SLOT_W-1:0] rnd_slot();
        return SLOT_W'($urandom);
    endfunction

    function automatic logic [LINKS_W-1:0] rnd_links();
        return LINKS_W'($urandom);
    endfunction

    task automatic send(kind_t k, logic [DEVICE_W-1:0] d, logic [OBJECT_W-1:0] o,
                        logic [SLOT_W-1:0] s, logic [LINKS_W-1:0] l);
        req_t rq;
        rq.kind = k;
        rq.device = d;
        rq.object_number = o;
        rq.slot = s;
        rq.link_count = l;
        while (pending_reqs.size() >= 4)
            @(posedge clk);
        pending_reqs.push_back(rq);
        items_queued++;
    endtask

    task automatic settle();
        while (items_accepted != items_queued || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SLOT_W-1:0] live_slot();
        int live[$];
        int i;
        for (i = 0; i < ENTRIES_DEF; i++)
            if (refs_held[i] != 0)
                live.push_back(i);
        if (live.size() == 0)
            return SLOT_W'($urandom_range(ENTRIES_DEF - 1));
        return SLOT_W'(live[$urandom_range(live.size() - 1)]);
    endfunction

    function automatic logic [LINKS_W-1:0] some_links();
        if ($urandom_range(1) == 0)
            return '0;
        return LINKS_W'($urandom);
    endfunction

    task automatic churn(int n);
        int j;
        int pick;
        int k;
        for (j = 0; j < n; j++)
        begin
            pick = $urandom_range(99);
            k = $urandom_range(POOL - 1);
            if (pick < 40 && $urandom_range(4) == 0)
                send(KIND_GET, rnd_dev(), rnd_obj(), rnd_slot(), rnd_links());
            else if (pick < 40)
                send(KIND_GET, pool_dev[k], pool_obj[k], rnd_slot(), rnd_links());
            else if (pick < 60)
                send(KIND_DUP, rnd_dev(), rnd_obj(), live_slot(), rnd_links());
            else if (pick < 85)
                send(KIND_PUT, rnd_dev(), rnd_obj(), live_slot(), rnd_links());
            else if (pick < 95)
                send(KIND_LOADED, rnd_dev(), rnd_obj(), live_slot(), some_links());
            else
                send(kind_t'($urandom_range(3)), rnd_dev(), rnd_obj(), rnd_slot(),
                     rnd_links());
        end
    endtask

    task automatic drop_all();
        int i;
        int held[ENTRIES_DEF];
        settle();
        for (i = 0; i < ENTRIES_DEF; i++)
            held[i] = int'(refs_held[i]);
        for (i = 0; i < ENTRIES_DEF; i++)
            repeat (held[i])
                send(KIND_PUT, '0, '0, SLOT_W'(i), '0);
        send(KIND_PUT, '1, '1, '1, '1);
        settle();
    endtask

    initial
    begin
        int i;
        int s;
        logic [DEVICE_W-1:0] hot_dev;
        logic [OBJECT_W-1:0] hot_obj;

        for (i = 0; i < ENTRIES_DEF; i++)
        begin
            refs_held[i] = '0;
            is_loaded[i] = 1'b0;
            key_dev[i] = '0;
            key_obj[i] = '0;
            link_held[i] = '0;
        end
        for (i = 0; i < POOL; i++)
        begin
            pool_dev[i] = rnd_dev();
            pool_obj[i] = rnd_obj();
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed corner cases on an empty table
        send(KIND_GET, '0, '0, '0, '0);
        send(KIND_GET, '1, '1, '0, '0);
        send(KIND_GET, '0, '0, '1, '1);
        send(KIND_DUP, '0, '0, 6'd0, '0);
        send(KIND_LOADED, '0, '0, 6'd0, '0);
        send(KIND_GET, '0, '0, '0, '0);
        send(KIND_DUP, '0, '0, 6'd0, '0);
        send(KIND_LOADED, '0, '0, 6'd1, '1);
        send(KIND_LOADED, '0, '0, 6'd1, 16'h8000);
        send(KIND_PUT, '0, '0, 6'd1, '0);
        send(KIND_GET, '1, '1, '0, '0);
        repeat (5)
            send(KIND_PUT, '0, '0, 6'd0, '0);
        send(KIND_PUT, '0, '0, 6'd0, '0);
        send(KIND_DUP, '0, '0, 6'd63, '0);
        send(KIND_LOADED, '0, '0, 6'd63, '1);
        send(KIND_PUT, '0, '0, 6'd62, '0);
        send(KIND_PUT, '0, '0, 6'd1, '0);
        send(KIND_GET, 8'hA5, 16'h5A5A, '0, '0);
        settle();

        // count saturation on one entry
        sender_idle_pct = 25;
        hot_dev = rnd_dev();
        hot_obj = rnd_obj();
        send(KIND_GET, hot_dev, hot_obj, '0, '0);
        settle();
        s = 0;
        for (i = ENTRIES_DEF - 1; i >= 0; i--)
            if (refs_held[i] != 0 && key_dev[i] == hot_dev && key_obj[i] == hot_obj)
                s = i;
        repeat (int'(REF_TOP) - 2)
            send(KIND_DUP, rnd_dev(), rnd_obj(), SLOT_W'(s), rnd_links());
        repeat (2)
            send(KIND_GET, hot_dev, hot_obj, rnd_slot(), rnd_links());
        repeat (2)
            send(KIND_DUP, rnd_dev(), rnd_obj(), SLOT_W'(s), rnd_links());
        send(KIND_LOADED, '0, '0, SLOT_W'(s), '0);
        sender_idle_pct = 0;
        repeat (int'(REF_TOP) + 1)
            send(KIND_PUT, rnd_dev(), rnd_obj(), SLOT_W'(s), rnd_links());
        settle();

        // random traffic
        sender_idle_pct = 50;
        churn(50);
        settle();

        // fill the table past its capacity
        sender_idle_pct = 0;
        repeat (ENTRIES_DEF + 8)
            send(KIND_GET, rnd_dev(), rnd_obj(), rnd_slot(), rnd_links());
        settle();
        sender_idle_pct = 50;
        repeat (ENTRIES_DEF)
            send(KIND_LOADED, rnd_dev(), rnd_obj(), live_slot(), some_links());
        sender_idle_pct = 25;
        drop_all();

        churn(30);
        sender_idle_pct = 0;
        churn(30);
        settle();

        repeat (ENTRIES_DEF + 8) @(posedge clk);
        if (expected_rsps.size() != 0)
            fault_count++;
        $display("%0d requests, %0d results checked", items_accepted, results_checked);
        $display("hits %0d, full %0d, overflow %0d, unreferenced %0d, releases %0d",
                 n_hit, n_full, n_overflow, n_unref, n_release);
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ricache_pkg.sv
rtl/core/ricache_ram.sv
rtl/core/ricache_ctrl.sv
rtl/core/ricache_dp.sv
rtl/core/refcounted_inode_cache_table_unit.sv
test/tb.sv
